// ===== rtl/crse_pkg.sv =====
// Types and codes shared by the cyclic register spill evaluator.
package crse_pkg;

   typedef enum logic [2:0] {
      FUNC_LDC   = 3'd0,
      FUNC_LDV   = 3'd1,
      FUNC_BINOP = 3'd2,
      FUNC_STORE = 3'd3,
      FUNC_PRINT = 3'd4,
      FUNC_FLUSH = 3'd5,
      FUNC_RSVD6 = 3'd6,
      FUNC_RSVD7 = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_DIVZERO   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_EXEC,
      S_RESP
   } state_type;

endpackage

// ===== rtl/cyclic_register_spill_evaluator.sv =====
// Top level of the cyclic register spill evaluator.
// Most words pass through a memory read and then execute, and the result is registered.
// A divide adds a pass through a one-bit-per-cycle restoring divider.
// One word is in flight at a time; a word is accepted while the
// previous result waits, and execute holds until that result is taken.
// Reset: synchronous, clears registers, pointers and pending state; the variable
// store reads as zero through per-entry valid bits. Spill stack has no reset.
module cyclic_register_spill_evaluator #(
   parameter int NUM_REGS    = 4,
   parameter int SPILL_DEPTH = 1024,
   parameter int NUM_VARS    = 128,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_func,
   input  logic [1:0]          req_op,
   input  logic signed [31:0]  req_value,
   input  logic [6:0]          req_var_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_print_valid,
   output logic signed [31:0]  rsp_print_value,
   output logic [1:0]          rsp_status
);
   import crse_pkg::*;

   localparam int RW = $clog2(NUM_REGS + 1);
   localparam int SW = $clog2(SPILL_DEPTH + 1);
   localparam int SA = $clog2(SPILL_DEPTH);
   localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
   localparam int DW = DATA_WIDTH;
   localparam int CW = $clog2(DW + 1);

   state_type state_ff, state_in;

   logic [DW-1:0] regs_ff [NUM_REGS];
   logic [RW-1:0] cur_ff;
   logic [SW-1:0] depth_ff;
   logic          pend_ff, pend_var_ff;
   logic [DW-1:0] pend_val_ff;
   logic [VW-1:0] pend_idx_ff;

   logic [DW-1:0] spill_mem [SPILL_DEPTH];
   logic [DW-1:0] var_mem [NUM_VARS];
   logic [NUM_VARS-1:0] var_ok_ff;
   logic [DW-1:0] spill_rd_ff, var_rd_ff;
   logic          var_rd_ok_ff;

   logic [2:0]    func_ff;
   logic [1:0]    op_ff;
   logic [DW-1:0] value_ff;
   logic [VW-1:0] vidx_ff;

   logic          rv_ff, rpv_ff;
   logic [31:0]   rval_ff;
   logic [1:0]    rst_ff;

   // divider
   logic [DW-1:0] dq_ff, dr_ff, dd_ff;
   logic          dneg_ff;
   logic [CW-1:0] dcnt_ff;

   logic accept, exec_go, div_start;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign exec_go   = (state_ff == S_EXEC) && !rv_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: if (exec_go) state_in = (div_start) ? S_DIV : S_IDLE;
         S_DIV:  if (dcnt_ff == CW'(0)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // read addresses
   logic [SA-1:0] pop_addr;
   logic [VW-1:0] vrd_addr;
   assign pop_addr = SA'(depth_ff - SW'(1));
   always_comb begin
      vrd_addr = pend_idx_ff;
      if (func_ff == FUNC_BINOP) vrd_addr = pend_idx_ff;
   end

   always_ff @(posedge clock) begin
      spill_rd_ff  <= spill_mem[pop_addr];
      var_rd_ff    <= var_mem[vrd_addr];
      var_rd_ok_ff <= var_ok_ff[vrd_addr];
   end

   // execute decode
   function automatic logic [DW-1:0] rget(input logic [RW-1:0] k,
                                          input logic [DW-1:0] r [NUM_REGS]);
      logic [DW-1:0] v;
      v = '0;
      for (int i = 0; i < NUM_REGS; i++)
         if (k == RW'(i + 1)) v = r[i];
      return v;
   endfunction

   logic [DW-1:0] pval, curv, dv, a, b, alu_r;
   logic [RW-1:0] d_reg, nxt_reg, prv_reg;
   logic          fspill, fovf, need_pop, is_flush_func, do_flush;
   logic          a_neg, b_neg;
   logic [DW-1:0] ua, ub;

   always_comb begin
      pval    = pend_var_ff ? (var_rd_ok_ff ? var_rd_ff : '0) : pend_val_ff;
      curv    = rget(cur_ff, regs_ff);
      d_reg   = (cur_ff < RW'(2)) ? RW'(NUM_REGS) : RW'(cur_ff - RW'(1));
      prv_reg = (cur_ff <= RW'(1)) ? RW'(NUM_REGS) : RW'(cur_ff - RW'(1));
      dv      = rget(d_reg, regs_ff);
      nxt_reg = (cur_ff >= RW'(NUM_REGS)) ? RW'(1) : RW'(cur_ff + RW'(1));
      fspill  = (cur_ff >= RW'(NUM_REGS)) || (depth_ff != '0);
      fovf    = pend_ff && fspill && (depth_ff >= SW'(SPILL_DEPTH));
      need_pop = (cur_ff <= RW'(1)) || (depth_ff != '0);
      is_flush_func = (func_ff inside {FUNC_LDC, FUNC_LDV, FUNC_STORE,
                                       FUNC_PRINT, FUNC_FLUSH});
      do_flush = is_flush_func && pend_ff && !fovf;
      if (pend_ff) begin
         a = curv; b = pval;
      end else begin
         a = dv; b = curv;
      end
      case (op_ff)
         OP_ADD:  alu_r = a + b;
         OP_SUB:  alu_r = a - b;
         OP_MUL:  alu_r = DW'(a * b);
         default: alu_r = '0;
      endcase
      a_neg = a[DW-1];
      b_neg = b[DW-1];
      ua    = a_neg ? -a : a;
      ub    = b_neg ? -b : b;
      div_start = exec_go && (func_ff == FUNC_BINOP) &&
                  (op_ff == OP_DIV) && (b != '0) &&
                  (pend_ff || !(need_pop && depth_ff == '0));
   end

   // divider datapath
   logic [DW:0] trial;
   assign trial = {dr_ff, dq_ff[DW-1]} - {1'b0, dd_ff};

   always_ff @(posedge clock) begin
      if (div_start) begin
         dq_ff   <= ua;
         dr_ff   <= '0;
         dd_ff   <= ub;
         dneg_ff <= a_neg ^ b_neg;
      end else if (state_ff == S_DIV && dcnt_ff != CW'(0)) begin
         if (!trial[DW]) begin
            dr_ff <= trial[DW-1:0];
            dq_ff <= {dq_ff[DW-2:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[DW-2:0], dq_ff[DW-1]};
            dq_ff <= {dq_ff[DW-2:0], 1'b0};
         end
      end
   end

   logic [DW-1:0] qres;
   assign qres = dneg_ff ? -dq_ff : dq_ff;

   // state update
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         op_ff    <= req_op;
         value_ff <= DW'(req_value);
         vidx_ff  <= VW'(req_var_index);
      end
      if (exec_go) begin
         if (do_flush) begin
            if (fspill) spill_mem[SA'(depth_ff)] <= rget(nxt_reg, regs_ff);
         end else if (func_ff == FUNC_BINOP && !pend_ff && need_pop &&
                      depth_ff != '0 && op_ff != OP_DIV) begin
            // nothing written on pop
         end
         if (func_ff == FUNC_STORE && !fovf)
            var_mem[vidx_ff] <= pend_ff ? pval : curv;
      end
   end

   logic [1:0]    st;
   always_comb begin
      st = ST_OK;
      if (is_flush_func && fovf) st = ST_OVERFLOW;
      else if (func_ff == FUNC_BINOP) begin
         if (op_ff == OP_DIV && b == '0) st = ST_DIVZERO;
         else if (!pend_ff && need_pop && depth_ff == '0) st = ST_UNDERFLOW;
      end
   end

   logic [DW-1:0] binres;
   logic          bin_commit;
   assign binres = (state_ff == S_DIV) ? qres : alu_r;
   assign bin_commit = (exec_go && func_ff == FUNC_BINOP &&
                        st == ST_OK && op_ff != OP_DIV) ||
                       ((state_ff == S_DIV) && dcnt_ff == CW'(0));

   logic [DW-1:0] pdata;
   assign pdata = pend_ff ? pval : curv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cur_ff      <= '0;
         depth_ff    <= '0;
         pend_ff     <= 1'b0;
         pend_var_ff <= 1'b0;
         pend_val_ff <= '0;
         pend_idx_ff <= '0;
         var_ok_ff   <= '0;
         rv_ff       <= 1'b0;
         rpv_ff      <= 1'b0;
         rval_ff     <= '0;
         rst_ff      <= ST_OK;
         dcnt_ff     <= '0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (div_start) dcnt_ff <= CW'(DW);
         else if (state_ff == S_DIV && dcnt_ff != CW'(0)) dcnt_ff <= dcnt_ff - CW'(1);
         if (exec_go) begin
            if (do_flush) begin
               if (func_ff != FUNC_FLUSH) begin
                  cur_ff <= nxt_reg;
                  if (fspill) depth_ff <= depth_ff + SW'(1);
               end
               for (int i = 0; i < NUM_REGS; i++)
                  if (nxt_reg == RW'(i + 1)) regs_ff[i] <= pval;
               if (func_ff != FUNC_LDC && func_ff != FUNC_LDV) pend_ff <= 1'b0;
            end
            if (func_ff == FUNC_STORE && !fovf) var_ok_ff[vidx_ff] <= 1'b1;
            if ((func_ff == FUNC_LDC || func_ff == FUNC_LDV) && !fovf) begin
               pend_ff     <= 1'b1;
               pend_var_ff <= (func_ff == FUNC_LDV);
               pend_val_ff <= value_ff;
               pend_idx_ff <= vidx_ff;
            end
            if (func_ff == FUNC_FLUSH && !fovf) begin
               cur_ff   <= '0;
               depth_ff <= '0;
            end
            if (!div_start) begin
               rv_ff   <= 1'b1;
               rst_ff  <= st;
               rpv_ff  <= (func_ff == FUNC_PRINT) && !fovf;
               rval_ff <= ((func_ff == FUNC_PRINT) && !fovf) ? 32'(signed'(pdata)) : '0;
            end
         end
         if (bin_commit) begin
            if (pend_ff) begin
               for (int i = 0; i < NUM_REGS; i++)
                  if (cur_ff == RW'(i + 1)) regs_ff[i] <= binres;
               pend_ff <= 1'b0;
            end else begin
               for (int i = 0; i < NUM_REGS; i++) begin
                  if (d_reg == RW'(i + 1)) regs_ff[i] <= binres;
                  else if (need_pop && cur_ff == RW'(i + 1)) regs_ff[i] <= spill_rd_ff;
               end
               if (need_pop) depth_ff <= depth_ff - SW'(1);
               cur_ff <= prv_reg;
            end
            if (state_ff == S_DIV) begin
               rv_ff   <= 1'b1;
               rst_ff  <= ST_OK;
               rpv_ff  <= 1'b0;
               rval_ff <= '0;
            end
         end
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_print_valid = rpv_ff;
   assign rsp_print_value = rval_ff;
   assign rsp_status      = rst_ff;

   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= SW'(SPILL_DEPTH)) else $error("spill depth beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      cur_ff <= RW'(NUM_REGS)) else $error("register pointer out of range");
   assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_print_valid |-> rsp_print_value == '0)
      else $error("print value without print");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("accepted while busy");
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the cyclic register spill evaluator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import crse_pkg::*;

   localparam int NREGS = 4;
   localparam int SDEPTH = 1024;
   localparam int NVARS = 128;

   typedef struct packed {
      logic        print_valid;
      logic [31:0] print_value;
      logic [1:0]  status;
   } word_type;

   class evaluator_scoreboard;
      logic [31:0] regs[NREGS];
      int          cur;
      int          depth;
      logic [31:0] spill[SDEPTH];
      logic [31:0] vars[NVARS];
      bit          pend;
      bit          pend_var;
      logic [31:0] pend_opnd;
      word_type    expected_words[$];
      int          errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (vars[i]) vars[i] = '0;
         cur = 0; depth = 0; pend = 0; pend_var = 0; pend_opnd = '0;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function logic [31:0] rget(int k);
         return (k >= 1 && k <= NREGS) ? regs[k-1] : 32'd0;
      endfunction

      function void rset(int k, logic [31:0] v);
         if (k >= 1 && k <= NREGS) regs[k-1] = v;
      endfunction

      function logic [31:0] pval();
         return pend_var ? vars[pend_opnd[6:0]] : pend_opnd;
      endfunction

      function status_type alu(op_type op, logic [31:0] a, logic [31:0] b,
                               output logic [31:0] r);
         r = '0;
         case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: begin
               if (b == 0) return ST_DIVZERO;
               if (a == 32'h8000_0000 && b == 32'hffff_ffff) r = a;
               else r = $signed(a) / $signed(b);
            end
         endcase
         return ST_OK;
      endfunction

      function status_type flush_pend();
         bit sp;
         logic [31:0] v;
         if (!pend) return ST_OK;
         sp = cur >= NREGS || depth != 0;
         if (sp && depth >= SDEPTH) return ST_OVERFLOW;
         v = pval();
         cur = (cur >= NREGS) ? 1 : cur + 1;
         if (sp) begin
            spill[depth] = rget(cur);
            depth++;
         end
         rset(cur, v);
         pend = 0;
         return ST_OK;
      endfunction

      function void note_input(logic [2:0] f, logic [1:0] op, logic [31:0] value,
                               logic [6:0] idx);
         word_type w;
         status_type st;
         logic [31:0] r;
         int d;
         bit pop;
         w = '0;
         st = ST_OK;
         case (f)
            FUNC_LDC, FUNC_LDV: begin
               st = flush_pend();
               if (st == ST_OK) begin
                  pend = 1;
                  pend_var = (f == FUNC_LDV);
                  pend_opnd = (f == FUNC_LDV) ? {25'd0, idx} : value;
               end
            end
            FUNC_BINOP: begin
               if (pend) begin
                  st = alu(op_type'(op), rget(cur), pval(), r);
                  if (st == ST_OK) begin
                     rset(cur, r);
                     pend = 0;
                  end
               end else begin
                  d = cur < 2 ? NREGS : cur - 1;
                  pop = cur <= 1 || depth != 0;
                  st = alu(op_type'(op), rget(d), rget(cur), r);
                  if (st == ST_OK && pop && depth == 0) st = ST_UNDERFLOW;
                  if (st == ST_OK) begin
                     rset(d, r);
                     if (pop) begin
                        depth--;
                        rset(cur, spill[depth]);
                     end
                     cur = (cur <= 1) ? NREGS : cur - 1;
                  end
               end
            end
            FUNC_STORE: begin
               st = flush_pend();
               if (st == ST_OK) vars[idx] = rget(cur);
            end
            FUNC_PRINT: begin
               st = flush_pend();
               if (st == ST_OK) begin
                  w.print_valid = 1;
                  w.print_value = rget(cur);
               end
            end
            FUNC_FLUSH: begin
               st = flush_pend();
               if (st == ST_OK) begin
                  cur = 0;
                  depth = 0;
               end
            end
            default: ;
         endcase
         w.status = st;
         expected_words.push_back(w);
      endfunction

      task check_result(input word_type got);
         word_type e;
         if (expected_words.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         e = expected_words.pop_front();
         if (got.print_valid !== e.print_valid)
            report($sformatf("print_valid %b, expected %b", got.print_valid, e.print_valid));
         if (got.print_value !== e.print_value)
            report($sformatf("print_value %h, expected %h", got.print_value, e.print_value));
         if (got.status !== e.status)
            report($sformatf("status %0d, expected %0d", got.status, e.status));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [1:0]  req_op = '0;
   logic signed [31:0] req_value = '0;
   logic [6:0]  req_var_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_print_valid;
   logic signed [31:0] rsp_print_value;
   logic [1:0]  rsp_status;

   evaluator_scoreboard sb = new();
   int stall_mode = 0;

   cyclic_register_spill_evaluator u_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_print_valid, rsp_print_value, rsp_status});
      if (!reset && req_valid && req_ready)
         sb.note_input(req_func, req_op, req_value, req_var_index);
   end

   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 2) == 0);
      endcase
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

   // Drive one word and hold it until accepted; back-to-back words stay valid.
   task automatic send(input logic [2:0] f, input logic [1:0] op,
                       input logic [31:0] v, input logic [6:0] idx);
      req_valid <= 1'b1;
      req_func <= f;
      req_op <= op;
      req_value <= v;
      req_var_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle(1);
      while (sb.expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 20) - 10;
         default: return $urandom();
      endcase
   endfunction

   task automatic rand_item();
      int r;
      logic [2:0] f;
      r = $urandom_range(0, 99);
      if (r < 30) f = FUNC_LDC;
      else if (r < 45) f = FUNC_LDV;
      else if (r < 75) f = FUNC_BINOP;
      else if (r < 83) f = FUNC_STORE;
      else if (r < 93) f = FUNC_PRINT;
      else if (r < 97) f = FUNC_FLUSH;
      else if (r < 99) f = FUNC_RSVD6;
      else f = FUNC_RSVD7;
      send(f, 2'($urandom_range(0, 3)), rand_value(), 7'($urandom_range(0, 127)));
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(FUNC_PRINT, OP_ADD, '0, 7'd0);
      send(FUNC_BINOP, OP_ADD, '0, 7'd0);
      send(FUNC_LDC, OP_ADD, 32'h8000_0000, 7'd0);
      send(FUNC_LDC, OP_ADD, 32'hffff_ffff, 7'd0);
      send(FUNC_BINOP, OP_DIV, '0, 7'd0);
      send(FUNC_PRINT, OP_ADD, '0, 7'd0);
      send(FUNC_STORE, OP_ADD, '0, 7'd127);
      send(FUNC_LDC, OP_ADD, 32'd0, 7'd0);
      send(FUNC_BINOP, OP_DIV, '0, 7'd0);
      send(FUNC_LDV, OP_ADD, '0, 7'd127);
      send(FUNC_LDC, OP_ADD, 32'h7fff_ffff, 7'd0);
      send(FUNC_LDC, OP_ADD, 32'd3, 7'd0);
      send(FUNC_LDC, OP_ADD, 32'd5, 7'd0);
      send(FUNC_BINOP, OP_SUB, '0, 7'd0);
      send(FUNC_BINOP, OP_MUL, '0, 7'd0);
      send(FUNC_BINOP, OP_ADD, '0, 7'd0);
      send(FUNC_BINOP, OP_SUB, '0, 7'd0);
      send(FUNC_PRINT, OP_ADD, '0, 7'd0);
      send(FUNC_RSVD6, OP_ADD, '0, 7'd0);
      send(FUNC_RSVD7, OP_ADD, '0, 7'd0);
      send(FUNC_FLUSH, OP_ADD, '0, 7'd0);
      drain();

      // Build a deep spill stack, then unwind past underflow.
      stall_mode = 1;
      for (int i = 0; i < 40; i++)
         send(FUNC_LDC, OP_ADD, $urandom(), 7'd0);
      for (int i = 0; i < 44; i++)
         send(FUNC_BINOP, 2'($urandom_range(0, 2)), '0, 7'd0);
      send(FUNC_PRINT, OP_ADD, '0, 7'd0);
      send(FUNC_FLUSH, OP_ADD, '0, 7'd0);
      drain();

      n = 0;
      while (n < 840) begin
         int burst;
         stall_mode = $urandom_range(0, 2);
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst; i++) begin
            rand_item();
            n++;
         end
         if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
         if (n > 450 && n < 475) drain();
      end
      drain();
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
